[sv/mcv_pkg.sv]
// Shared types and constants for the Matern 5/2 covariance core.
package mcv_pkg;

   localparam int ACC_W   = 40;
   localparam int ROOT_W  = 20;
   localparam int QUOT_W  = 40;
   localparam int DEN_W   = 16;
   localparam int R_W     = 21;
   localparam int POLY_W  = 27;
   localparam int T_W     = 32;
   localparam int PROD_W  = 64;
   localparam int K_W     = 4;
   localparam int SQN_W   = 3;

   localparam logic [17:0]    SQRT5_Q16   = 18'd146543;
   localparam logic [T_W-1:0] ONE_Q31     = 32'h8000_0000;
   localparam logic [K_W-1:0] EXP_TERMS   = 4'd9;
   localparam logic [SQN_W-1:0] SQ_LAST   = 3'd5;
   // ceil(2^33 / 3): x * RECIP3 >> 33 equals x / 3 for any 32-bit x
   localparam logic [T_W-1:0] RECIP3      = 32'hAAAA_AAAB;

   // Register indexes
   localparam logic CSR_LENGTH_SCALE = 1'b0;
   localparam logic CSR_VARIANCE     = 1'b1;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_ACC,
      OP_SQRT_START,
      OP_MUL_D,
      OP_DIV_R,
      OP_SET_R,
      OP_MUL_RR,
      OP_MUL_P3,
      OP_POLY,
      OP_MUL_XT,
      OP_DIV_K,
      OP_T_K,
      OP_MUL_TT,
      OP_T_SQ,
      OP_MUL_PE,
      OP_MUL_VF,
      OP_OUT
   } dp_op_type;

   typedef enum logic [4:0] {
      S_ACC,
      S_SQRT_GO,
      S_SQRT_WAIT,
      S_MUL_D,
      S_DIV_R_GO,
      S_DIV_R_WAIT,
      S_SET_R,
      S_MUL_RR,
      S_MUL_P3,
      S_POLY,
      S_MUL_XT,
      S_DIV_K_GO,
      S_DIV_K_WAIT,
      S_T_K,
      S_MUL_TT,
      S_T_SQ,
      S_MUL_PE,
      S_F,
      S_MUL_VF,
      S_DONE
   } state_type;

   typedef struct packed {
      dp_op_type      op;
      logic [K_W-1:0] k;
   } cmd_type;

   typedef struct packed {
      logic sqrt_done;
      logic div_done;
      logic zero_sum;
      logic r_big;
      logic out_free;
   } status_type;

endpackage

[sv/matern52_covariance_core.sv]
// Top level of the Matern 5/2 covariance core.
//
//   channel  dir  tdata                               tuser       tlast
//   req      in   [15:0] coord_a, [31:16] coord_b     -           last pair
//   rsp      out  [15:0] covariance                   saturated   -
//   csr      in   csr_addr 0 length_scale, 1 signal_variance, 16-bit data
//
// Coordinate pairs are taken one per cycle while the core waits in its
// accumulate state. After the pair marked last the core runs its kernel tail:
// a square root, then divides in one shared divider (ten of them) and one
// shared 32x32 multiplier; zero distance skips straight to the result. A result waits in
// the output register; the next point pair is taken while it waits.
// Reset is synchronous and restores both registers to 1.0.
module matern52_covariance_core
   import mcv_pkg::*;
#(
   parameter int MAX_DIM = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [15:0] coord_a, [31:16] coord_b
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] covariance
   output logic        rsp_tuser,   // [0] saturated
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   mcv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   mcv_datapath #(
      .MAX_DIM (MAX_DIM)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .coord_a    (req_tdata[15:0]),
      .coord_b    (req_tdata[31:16]),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .covariance (rsp_tdata),
      .saturated  (rsp_tuser)
   );

endmodule

[sv/mcv_sqrt.sv]
// Iterative integer square root, one result bit per cycle.
module mcv_sqrt
   import mcv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [ACC_W-1:0]  operand,
   output logic              done,
   output logic              busy,
   output logic [ROOT_W-1:0] root
);

   localparam int REM_W = ROOT_W + 4;
   localparam int CNT_W = $clog2(ROOT_W);

   logic [ACC_W-1:0]  v_ff, v_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;

   // Shift in two operand bits, try the next root bit
   always_comb begin
      rem_sh  = {rem_ff[REM_W-3:0], v_ff[ACC_W-1 -: 2]};
      trial   = REM_W'({root_ff, 2'b01});
      v_in    = v_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         v_in    = operand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         v_in = {v_ff[ACC_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(ROOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      v_ff    <= v_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign busy = busy_ff;
   assign root = root_ff;

endmodule

[sv/mcv_div.sv]
// Restoring divider, one quotient bit per cycle.
module mcv_div
   import mcv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [QUOT_W-1:0] num,
   input  logic [DEN_W-1:0]  den,
   output logic              done,
   output logic              busy,
   output logic [QUOT_W-1:0] quot
);

   localparam int CNT_W = $clog2(QUOT_W);

   logic [QUOT_W-1:0] q_ff, q_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    trial;
   logic              ge;

   // Bring down one numerator bit, subtract when it fits
   always_comb begin
      trial   = {rem_ff, q_ff[QUOT_W-1]};
      ge      = trial >= {1'b0, den_ff};
      q_in    = q_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in    = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
         q_in   = {q_ff[QUOT_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QUOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign busy = busy_ff;
   assign quot = q_ff;

endmodule

[sv/mcv_datapath.sv]
// Datapath: accumulator, shared multiplier, sqrt and divide units, result register.
module mcv_datapath
   import mcv_pkg::*;
#(
   parameter int MAX_DIM = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [15:0] coord_a,
   input  logic [15:0] coord_b,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] covariance,
   output logic        saturated
);

   localparam int CNT_W = $clog2(MAX_DIM + 1);

   logic [15:0]        ls_ff, var_ff;
   logic [ACC_W-1:0]   sum_ff, sum_in;
   logic               ovf_ff, ovf_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [PROD_W-1:0]  mul_ff;
   logic [T_W-1:0]     mul_a, mul_b;
   logic               mul_en;
   logic [R_W-1:0]     r_ff;
   logic               r_big_ff;
   logic [POLY_W-1:0]  poly_ff;
   logic [T_W-1:0]     t_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        cov_ff;
   logic               sat_ff;

   logic signed [16:0] diff;
   logic [16:0]        mag;
   logic [33:0]        sq;
   logic [ACC_W:0]     sum_wide;
   logic [15:0]        ls_eff;
   logic [QUOT_W-1:0]  div_num;
   logic [DEN_W-1:0]   div_den;
   logic               div_start, div_done, div_busy;
   logic [QUOT_W-1:0]  quot;
   logic               sqrt_start, sqrt_done, sqrt_busy;
   logic [ROOT_W-1:0]  root;
   logic [42:0]        p_round;
   logic [PROD_W-1:0]  t_round;
   logic [42:0]        c_round;
   logic [15:0]        cov_val;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ls_ff  <= 16'd256;
         var_ff <= 16'd256;
      end else if (csr_we) begin
         if (csr_addr == CSR_LENGTH_SCALE) begin
            ls_ff <= csr_wdata;
         end else begin
            var_ff <= csr_wdata;
         end
      end
   end

   assign ls_eff = (ls_ff == 16'd0) ? 16'd1 : ls_ff;

   // Accumulate squared difference, saturate, drop pairs beyond MAX_DIM
   always_comb begin
      diff     = $signed({coord_a[15], coord_a}) - $signed({coord_b[15], coord_b});
      mag      = diff[16] ? 17'(-diff) : 17'(diff);
      sq       = mag * mag;
      sum_wide = {1'b0, sum_ff} + (ACC_W + 1)'(sq);
      sum_in   = sum_ff;
      ovf_in   = ovf_ff;
      cnt_in   = cnt_ff;
      if (cmd.op == OP_ACC) begin
         if (cnt_ff >= CNT_W'(MAX_DIM)) begin
            ovf_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
            if (sum_wide[ACC_W]) begin
               sum_in = '1;
               ovf_in = 1'b1;
            end else begin
               sum_in = sum_wide[ACC_W-1:0];
            end
         end
      end else if (cmd.op == OP_OUT) begin
         sum_in = '0;
         ovf_in = 1'b0;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         ovf_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         ovf_ff <= ovf_in;
         cnt_ff <= cnt_in;
      end
   end

   // r*r rounded to Q.16 before the divide by three
   assign p_round = mul_ff[42:0] + 43'd98304;

   // Select multiplier operands
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (cmd.op)
         OP_MUL_D: begin
            mul_a = T_W'(root);
            mul_b = T_W'(SQRT5_Q16);
         end
         OP_MUL_RR: begin
            mul_a = T_W'(r_ff);
            mul_b = T_W'(r_ff);
         end
         OP_MUL_P3: begin
            mul_a = T_W'(p_round[42:16]);
            mul_b = RECIP3;
         end
         OP_MUL_XT: begin
            mul_a = T_W'({r_ff, 9'b0});
            mul_b = t_ff;
         end
         OP_MUL_TT: begin
            mul_a = t_ff;
            mul_b = t_ff;
         end
         OP_MUL_PE: begin
            mul_a = T_W'(poly_ff);
            mul_b = t_ff;
         end
         OP_MUL_VF: begin
            mul_a = T_W'(var_ff);
            mul_b = t_ff;
         end
         default: mul_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mul_en) begin
         mul_ff <= mul_a * mul_b;
      end
   end

   // Select divider operands
   always_comb begin
      div_start  = 1'b1;
      div_num    = '0;
      div_den    = ls_eff;
      case (cmd.op)
         OP_DIV_R: begin
            div_num = mul_ff[QUOT_W-1:0] + QUOT_W'(ls_eff >> 1);
            div_den = ls_eff;
         end
         OP_DIV_K: begin
            div_num = QUOT_W'(mul_ff[62:31]);
            div_den = DEN_W'(cmd.k);
         end
         default: div_start = 1'b0;
      endcase
   end

   assign sqrt_start = (cmd.op == OP_SQRT_START);

   mcv_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sum_ff),
      .done    (sqrt_done),
      .busy    (sqrt_busy),
      .root    (root)
   );

   mcv_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .busy  (div_busy),
      .quot  (quot)
   );

   // Working registers for r, polynomial and exponential term
   assign t_round = mul_ff + PROD_W'(64'h4000_0000);

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_SET_R: begin
            r_ff     <= quot[R_W-1:0];
            r_big_ff <= |quot[QUOT_W-1:R_W];
         end
         OP_POLY: begin
            // reciprocal product shifted down by 33 gives the quotient by three
            poly_ff <= POLY_W'(17'h10000) + POLY_W'(r_ff) + mul_ff[59:33];
            t_ff    <= ONE_Q31;
         end
         OP_T_K:  t_ff <= ONE_Q31 - quot[T_W-1:0];
         OP_T_SQ: t_ff <= t_round[62:31];
         default: ;
      endcase
   end

   // Round and saturate the result; zero distance gives the variance, a large r gives zero
   always_comb begin
      c_round = mul_ff[42:0] + 43'd32768;
      if (sum_ff == '0) begin
         cov_val = var_ff;
      end else if (r_big_ff) begin
         cov_val = '0;
      end else if (|c_round[42:32]) begin
         cov_val = 16'hFFFF;
      end else begin
         cov_val = c_round[31:16];
      end
   end

   // Hold the result word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_OUT) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.op == OP_OUT) begin
         cov_ff <= cov_val;
         sat_ff <= ovf_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign covariance = cov_ff;
   assign saturated  = sat_ff;

   assign status.sqrt_done = sqrt_done;
   assign status.div_done  = div_done;
   assign status.zero_sum  = (sum_ff == '0);
   assign status.r_big     = r_big_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   ap_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(sqrt_busy && div_busy))
      else $error("sqrt and divider busy together");

   ap_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_DIM))
      else $error("pair count beyond MAX_DIM");

   ap_clear_after_out: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_OUT) |=> (sum_ff == '0) && !ovf_ff && (cnt_ff == '0))
      else $error("accumulator not cleared after result");

   ap_valid_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.op == OP_OUT))
      else $error("result word raised without load");

endmodule

[sv/mcv_ctrl.sv]
// Sequencer that steps the datapath through the kernel evaluation.
module mcv_ctrl
   import mcv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tlast,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type          state_ff, state_in;
   logic [K_W-1:0]     k_ff, k_in;
   logic [SQN_W-1:0]   sq_ff, sq_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_ACC:        if (req_tvalid && req_tlast) state_in = S_SQRT_GO;
         S_SQRT_GO:    state_in = status.zero_sum ? S_DONE : S_SQRT_WAIT;
         S_SQRT_WAIT:  if (status.sqrt_done) state_in = S_MUL_D;
         S_MUL_D:      state_in = S_DIV_R_GO;
         S_DIV_R_GO:   state_in = S_DIV_R_WAIT;
         S_DIV_R_WAIT: if (status.div_done) state_in = S_SET_R;
         S_SET_R:      state_in = S_MUL_RR;
         S_MUL_RR:     state_in = status.r_big ? S_DONE : S_MUL_P3;
         S_MUL_P3:     state_in = S_POLY;
         S_POLY:       state_in = S_MUL_XT;
         S_MUL_XT:     state_in = S_DIV_K_GO;
         S_DIV_K_GO:   state_in = S_DIV_K_WAIT;
         S_DIV_K_WAIT: if (status.div_done) state_in = S_T_K;
         S_T_K:        state_in = (k_ff == K_W'(1)) ? S_MUL_TT : S_MUL_XT;
         S_MUL_TT:     state_in = S_T_SQ;
         S_T_SQ:       state_in = (sq_ff == SQ_LAST) ? S_MUL_PE : S_MUL_TT;
         S_MUL_PE:     state_in = S_F;
         S_F:          state_in = S_MUL_VF;
         S_MUL_VF:     state_in = S_DONE;
         S_DONE:       if (status.out_free) state_in = S_ACC;
         default:      state_in = S_ACC;
      endcase
   end

   // Loop counters for the series and the squarings
   always_comb begin
      k_in  = k_ff;
      sq_in = sq_ff;
      case (state_ff)
         S_POLY: k_in = EXP_TERMS;
         S_T_K: begin
            k_in  = k_ff - 1'b1;
            sq_in = '0;
         end
         S_T_SQ:  sq_in = sq_ff + 1'b1;
         default: ;
      endcase
   end

   // Commands
   always_comb begin
      req_tready = 1'b0;
      cmd.k      = k_ff;
      cmd.op     = OP_NONE;
      case (state_ff)
         S_ACC: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_ACC;
         end
         S_SQRT_GO:  if (!status.zero_sum) cmd.op = OP_SQRT_START;
         S_MUL_D:    cmd.op = OP_MUL_D;
         S_DIV_R_GO: cmd.op = OP_DIV_R;
         S_SET_R:    cmd.op = OP_SET_R;
         S_MUL_RR:   if (!status.r_big) cmd.op = OP_MUL_RR;
         S_MUL_P3:   cmd.op = OP_MUL_P3;
         S_POLY:     cmd.op = OP_POLY;
         S_MUL_XT:   cmd.op = OP_MUL_XT;
         S_DIV_K_GO: cmd.op = OP_DIV_K;
         S_T_K:      cmd.op = OP_T_K;
         S_MUL_TT:   cmd.op = OP_MUL_TT;
         S_T_SQ:     cmd.op = OP_T_SQ;
         S_MUL_PE:   cmd.op = OP_MUL_PE;
         S_F:        cmd.op = OP_T_SQ;
         S_MUL_VF:   cmd.op = OP_MUL_VF;
         S_DONE:     if (status.out_free) cmd.op = OP_OUT;
         default:    cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_ACC;
         k_ff     <= '0;
         sq_ff    <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         sq_ff    <= sq_in;
      end
   end

endmodule

[test/testbench.sv]
// Self-checking testbench for the Matern 5/2 covariance core.
module testbench;
   import mcv_pkg::*;

   localparam int MAX_PAIRS  = 64;
   localparam int TAIL_WAIT  = 700;
   localparam int DOG_LIMIT  = 200000;

   typedef struct {
      logic [15:0] cov;
      logic        sat;
   } cov_word_type;

   typedef struct {
      logic [15:0] a;
      logic [15:0] b;
      logic        lst;
      logic        chk;   // typed-in expectation present
      logic [15:0] cov;
      logic        sat;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_we = 1'b0;
   logic        csr_addr = CSR_LENGTH_SCALE;
   logic [15:0] csr_wdata = '0;

   // Predictor state and settings
   logic [15:0]     p_scale;
   logic [15:0]     p_var;
   logic [ACC_W:0]  p_sum;
   logic            p_ovf;
   int              p_count;
   cov_word_type    cov_queue[$];

   int errors = 0;
   int dog = 0;
   int send_idle = 0;
   int recv_stall = 0;
   stim_row_type dir_rows[$];

   matern52_covariance_core #(.MAX_DIM(MAX_PAIRS)) dut (.*);

   always #5 clock = ~clock;

   function automatic logic [63:0] root40(logic [63:0] v);
      logic [63:0] res, bt;
      res = 0;
      bt = 64'd1 << 40;
      while (bt > v) bt = bt >> 2;
      while (bt != 0) begin
         if (v >= res + bt) begin
            v = v - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return res;
   endfunction

   function automatic logic [63:0] exp_neg(logic [63:0] r);
      logic [63:0] x, t;
      x = r << 9;
      t = 64'h8000_0000;
      for (int k = 9; k >= 1; k--) t = 64'h8000_0000 - ((x * t) >> 31) / k;
      for (int i = 0; i < 6; i++) t = (t * t + 64'h4000_0000) >> 31;
      return t;
   endfunction

   function automatic logic [15:0] matern_cov(logic [63:0] sum, logic [63:0] ls,
                                              logic [63:0] vr);
      logic [63:0] d, r, poly, e, f, c;
      if (sum == 0) return vr[15:0];
      if (ls == 0) ls = 1;
      d = root40(sum);
      r = (d * 146543 + (ls >> 1)) / ls;
      if (r >= (64'd32 << 16)) return 16'd0;
      poly = 65536 + r + (r * r + 98304) / 196608;
      e = exp_neg(r);
      f = (poly * e + 64'h4000_0000) >> 31;
      c = (vr * f + 32768) >> 16;
      return (c > 65535) ? 16'hFFFF : c[15:0];
   endfunction

   // Advance the predictor by one accepted coordinate word
   task automatic accumulate_pair(logic [15:0] a, logic [15:0] b, logic lst);
      int signed df;
      logic [63:0] sq;
      cov_word_type w;
      df = $signed(a) - $signed(b);
      if (df < 0) df = -df;
      sq = df * df;
      if (p_count >= MAX_PAIRS) begin
         p_ovf = 1'b1;
      end else begin
         p_count++;
         p_sum = p_sum + sq;
         if (p_sum > {1'b0, {ACC_W{1'b1}}}) begin
            p_sum = {1'b0, {ACC_W{1'b1}}};
            p_ovf = 1'b1;
         end
      end
      if (lst) begin
         w.cov = matern_cov(p_sum, p_scale, p_var);
         w.sat = p_ovf;
         cov_queue.push_back(w);
         p_sum = 0;
         p_ovf = 1'b0;
         p_count = 0;
      end
   endtask

   // Check results and run the no-progress watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) dog <= 0;
         else dog <= dog + 1;
         if (dog >= DOG_LIMIT) begin
            $display("matern52_covariance_core test failed");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cov_queue.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected word cov=%h sat=%b",
                                          rsp_tdata, rsp_tuser);
            end else begin
               cov_word_type w;
               w = cov_queue.pop_front();
               if (rsp_tdata !== w.cov || rsp_tuser !== w.sat) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp cov=%h sat=%b got cov=%h sat=%b",
                              w.cov, w.sat, rsp_tdata, rsp_tuser);
               end
            end
         end
      end
   end

   // Randomly stall the receiver
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   // Write one register, then return the write enable low before going on
   task automatic write_reg(logic adr, logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= adr;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (adr == CSR_LENGTH_SCALE) p_scale = val;
      else p_var = val;
      @(posedge clock);
   endtask

   task automatic drain();
      while (cov_queue.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);
   endtask

   // Send one word; valid stays high across back-to-back words
   task automatic send_pair(logic [15:0] a, logic [15:0] b, logic lst);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {b, a};
      req_tlast <= lst;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accumulate_pair(a, b, lst);
   endtask

   task automatic add_row(logic [15:0] a, logic [15:0] b, logic lst, logic chk,
                          logic [15:0] cov, logic sat);
      stim_row_type r;
      r.a = a; r.b = b; r.lst = lst; r.chk = chk; r.cov = cov; r.sat = sat;
      dir_rows.push_back(r);
   endtask

   // Send one point pair; report how many words it took
   task automatic random_point_pair(output int n);
      int dims, kind;
      logic [15:0] a, b;
      dims = ($urandom_range(9) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 4);
      kind = $urandom_range(3);
      for (int i = 0; i < dims; i++) begin
         a = 16'($urandom);
         case (kind)
            0: b = 16'(a + $urandom_range(0, 255) - 128);
            1: b = 16'(a + $urandom_range(0, 2047) - 1024);
            2: b = a;
            default: b = 16'($urandom);
         endcase
         send_pair(a, b, i == dims - 1);
      end
      n = dims;
   endtask

   initial begin
      int sent;
      p_scale = 16'd256;
      p_var = 16'd256;
      p_sum = 0;
      p_ovf = 1'b0;
      p_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: zero distance gives variance, huge distance gives zero
      add_row(16'h0000, 16'h0000, 1'b1, 1'b1, 16'd256, 1'b0);
      add_row(16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 16'd256, 1'b0);
      add_row(16'h7FFF, 16'h8000, 1'b1, 1'b1, 16'd0, 1'b0);
      add_row(16'h8000, 16'h7FFF, 1'b1, 1'b1, 16'd0, 1'b0);
      add_row(16'h0100, 16'h0000, 1'b1, 1'b0, 16'd0, 1'b0);
      add_row(16'h0080, 16'h0000, 1'b0, 1'b0, 16'd0, 1'b0);
      add_row(16'hFF80, 16'h0000, 1'b1, 1'b0, 16'd0, 1'b0);
      add_row(16'h0001, 16'h0000, 1'b1, 1'b0, 16'd0, 1'b0);
      add_row(16'h5555, 16'hAAAA, 1'b1, 1'b0, 16'd0, 1'b0);
      foreach (dir_rows[i]) begin
         send_pair(dir_rows[i].a, dir_rows[i].b, dir_rows[i].lst);
         if (dir_rows[i].chk && cov_queue.size() != 0 &&
             (cov_queue[$].cov !== dir_rows[i].cov || cov_queue[$].sat !== dir_rows[i].sat)) begin
            errors++;
            if (errors <= 10) $display("row %0d: table cov=%h predicted cov=%h",
                                       i, dir_rows[i].cov, cov_queue[$].cov);
         end
      end
      // Too many coordinates: drop pairs beyond the limit
      for (int i = 0; i < MAX_PAIRS + 3; i++) send_pair(16'h0010, 16'h0000, i == MAX_PAIRS + 2);
      // Extreme differences over MAX_PAIRS pairs; the sum stays below accumulator saturation
      for (int i = 0; i < MAX_PAIRS; i++) send_pair(16'h7FFF, 16'h8000, i == MAX_PAIRS - 1);
      req_tvalid <= 1'b0;
      drain();

      // Extreme and mid settings, random traffic under each idling phase
      sent = 0;
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 87; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 87; end
            default: begin send_idle = 17; recv_stall = 17; end
         endcase
         case (ph)
            0: begin write_reg(CSR_LENGTH_SCALE, 16'd1);     write_reg(CSR_VARIANCE, 16'hFFFF); end
            1: begin write_reg(CSR_LENGTH_SCALE, 16'hFFFF);  write_reg(CSR_VARIANCE, 16'd1);    end
            2: begin write_reg(CSR_LENGTH_SCALE, 16'h0000);  write_reg(CSR_VARIANCE, 16'h0000); end
            default: begin
               write_reg(CSR_LENGTH_SCALE, 16'($urandom_range(1, 16'h7FFF)));
               write_reg(CSR_VARIANCE, 16'($urandom));
            end
         endcase
         while (sent < (ph + 1) * 88) begin
            int n;
            random_point_pair(n);
            sent += n;
         end
         req_tvalid <= 1'b0;
         drain();
      end

      if (errors == 0) $display("matern52_covariance_core test passed");
      else $display("matern52_covariance_core test failed");
      $finish;
   end
endmodule
